@@ rtl/i2crtc_pkg.sv @@
// shared types, constants and calendar helpers for the i2c rtc register file
package i2crtc_pkg;

    // store depth must be a power of two so the pointer wraps by truncation
    localparam int STORE_DEPTH = 64;
    localparam int PTR_W       = $clog2(STORE_DEPTH);
    localparam int TIME_REGS   = 7;

    localparam logic [2:0] KIND_START_READ  = 3'd0;
    localparam logic [2:0] KIND_START_WRITE = 3'd1;
    localparam logic [2:0] KIND_WRITE       = 3'd2;
    localparam logic [2:0] KIND_READ        = 3'd3;
    localparam logic [2:0] KIND_TICK        = 3'd4;

    localparam logic [PTR_W-1:0] CTRL_REG  = PTR_W'(7);
    localparam logic [7:0]       CTRL_MASK = 8'hB3;
    localparam logic [7:0]       OSF_BIT   = 8'h20;
    localparam logic [7:0]       HOUR_12   = 8'h40;
    localparam logic [7:0]       HOUR_PM   = 8'h20;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_CTRL,
        ST_READ
    } t_state;

    // binary 0..99 to packed bcd, tens by reciprocal multiply
    function automatic logic [7:0] bcd_out(input logic [6:0] v);
        logic [14:0] prod;
        logic [3:0]  tens;
        logic [6:0]  ones;
        prod = 15'(v) * 15'd205;
        tens = prod[14:11];
        ones = v - 7'(tens) * 7'd10;
        return {tens, ones[3:0]};
    endfunction

    // month length, an invalid month counts as january
    function automatic logic [4:0] days_in_month(input logic [3:0] m, input logic [6:0] y);
        logic [4:0] d;
        unique case (m)
            4'd2:                     d = (y[1:0] == 2'd0) ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:  d = 5'd30;
            default:                  d = 5'd31;
        endcase
        return d;
    endfunction

endpackage

@@ rtl/i2c_rtc_register_file_core.sv @@
// i2c rtc register file core: pointer, calendar counters, snapshot and byte store
//
// one command channel: a transaction is taken when start is high and busy is
// low; i_kind selects start read, start write, write byte, read byte or a
// one-second tick, i_data carries the written byte
// a read byte gives one result: o_valid is high for exactly one cycle, the
// cycle after the command, with o_read_data and o_read_index
// the receiver cannot stall, results are never held
// most commands finish without leaving idle; read byte, a control register write
// and a day, month or year write pass through a further state (busy high then)
// for the result strobe, the store read-modify-write or the day-of-month clamp
// registers 7 and up live in a synchronous ram with one write port and a
// registered read; the bcd snapshot of registers 0 to 6 sits in flops beside it
// reset (synchronous, active low) clears pointer and counters, sets the
// calendar to day 1 month 1 and clears the per-entry valid bits so the
// whole store reads as zero; no clearing pass is needed
module i2c_rtc_register_file_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  logic [2:0] i_kind,
    input  logic [7:0] i_data,
    output logic       busy,
    output logic       o_valid,
    output logic [7:0] o_read_data,
    output logic [5:0] o_read_index
);

    localparam int PW = i2crtc_pkg::PTR_W;

    i2crtc_pkg::t_state r_state, n_state;

    logic [PW-1:0] r_ptr, n_ptr;
    logic          r_aphase, n_aphase;
    logic [5:0]    r_sec, n_sec;
    logic [5:0]    r_min, n_min;
    logic [4:0]    r_hour, n_hour;
    logic [2:0]    r_wday, n_wday;
    logic [4:0]    r_day, n_day;
    logic [3:0]    r_mon, n_mon;
    logic [6:0]    r_year, n_year;
    logic          r_h12, n_h12;
    logic [PW-1:0] r_rd_idx, n_rd_idx;
    logic [7:0]    r_data;

    logic [7:0] r_snap [i2crtc_pkg::TIME_REGS];
    logic [7:0] n_snap [i2crtc_pkg::TIME_REGS];
    logic       do_snap;

    logic [7:0]                        r_mem [i2crtc_pkg::STORE_DEPTH];
    logic [i2crtc_pkg::STORE_DEPTH-1:0] r_vld;
    logic [7:0]                        r_rdata;
    logic                              r_rd_vld;
    logic                              mem_we;
    logic [PW-1:0]                     mem_wa;
    logic [7:0]                        mem_wd;

    function automatic logic [7:0] bcd_in(input logic [7:0] v);
        return 8'(v[7:4]) * 8'd10 + 8'(v[3:0]);
    endfunction

    assign busy = (r_state != i2crtc_pkg::ST_IDLE);

    // bcd view of the counters
    always_comb begin
        logic [4:0] h;
        n_snap[0] = i2crtc_pkg::bcd_out(7'(r_sec));
        n_snap[1] = i2crtc_pkg::bcd_out(7'(r_min));
        h = r_hour;
        if (r_h12) begin
            // midnight shows as 12 am, noon as 12 pm
            if (h == 5'd0) begin
                n_snap[2] = i2crtc_pkg::HOUR_12 | i2crtc_pkg::bcd_out(7'd12);
            end else if (h < 5'd12) begin
                n_snap[2] = i2crtc_pkg::HOUR_12 | i2crtc_pkg::bcd_out(7'(h));
            end else if (h == 5'd12) begin
                n_snap[2] = i2crtc_pkg::HOUR_12 | i2crtc_pkg::HOUR_PM
                          | i2crtc_pkg::bcd_out(7'd12);
            end else begin
                n_snap[2] = i2crtc_pkg::HOUR_12 | i2crtc_pkg::HOUR_PM
                          | i2crtc_pkg::bcd_out(7'(h - 5'd12));
            end
        end else begin
            n_snap[2] = i2crtc_pkg::bcd_out(7'(h));
        end
        n_snap[3] = 8'(r_wday) + 8'd1;
        n_snap[4] = i2crtc_pkg::bcd_out(7'(r_day));
        n_snap[5] = i2crtc_pkg::bcd_out(7'(r_mon));
        n_snap[6] = i2crtc_pkg::bcd_out(r_year);
    end

    always_comb begin
        logic [7:0] dec;
        logic [4:0] dim;
        logic [7:0] old;
        n_state  = r_state;
        n_ptr    = r_ptr;
        n_aphase = r_aphase;
        n_sec    = r_sec;
        n_min    = r_min;
        n_hour   = r_hour;
        n_wday   = r_wday;
        n_day    = r_day;
        n_mon    = r_mon;
        n_year   = r_year;
        n_h12    = r_h12;
        n_rd_idx = r_rd_idx;
        do_snap  = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = r_ptr;
        mem_wd   = i_data;
        dec      = 8'd0;
        dim      = i2crtc_pkg::days_in_month(r_mon, r_year);
        old      = r_rd_vld ? r_rdata : 8'd0;

        unique case (r_state)
            i2crtc_pkg::ST_IDLE: begin
                if (start) begin
                    unique case (i_kind)
                        i2crtc_pkg::KIND_START_READ: begin
                            do_snap = 1'b1;
                        end
                        i2crtc_pkg::KIND_START_WRITE: begin
                            n_aphase = 1'b1;
                        end
                        i2crtc_pkg::KIND_WRITE: begin
                            if (r_aphase) begin
                                n_ptr    = i_data[PW-1:0];
                                n_aphase = 1'b0;
                            end else if (r_ptr < PW'(i2crtc_pkg::TIME_REGS)) begin
                                n_ptr = r_ptr + PW'(1);
                                unique case (r_ptr[2:0])
                                    3'd0: begin
                                        dec   = bcd_in(i_data & 8'h7f);
                                        n_sec = (dec > 8'd59) ? 6'd59 : dec[5:0];
                                    end
                                    3'd1: begin
                                        dec   = bcd_in(i_data & 8'h7f);
                                        n_min = (dec > 8'd59) ? 6'd59 : dec[5:0];
                                    end
                                    3'd2: begin
                                        n_h12 = i_data[6];
                                        if (i_data[6]) begin
                                            dec = bcd_in(i_data & 8'h1f);
                                            if (dec > 8'd12) dec = 8'd12;
                                            if (dec < 8'd1) dec = 8'd1;
                                            if (i_data[5]) dec = dec + 8'd12;
                                            if (dec == 8'd12) begin
                                                dec = 8'd0;
                                            end else if (dec == 8'd24) begin
                                                dec = 8'd12;
                                            end
                                        end else begin
                                            dec = bcd_in(i_data & 8'h3f);
                                            if (dec > 8'd23) dec = 8'd23;
                                        end
                                        n_hour = dec[4:0];
                                    end
                                    3'd3: begin
                                        // code 0 and 7 both land on the last weekday
                                        if (i_data[2:0] == 3'd0 || i_data[2:0] == 3'd7) begin
                                            n_wday = 3'd6;
                                        end else begin
                                            n_wday = i_data[2:0] - 3'd1;
                                        end
                                    end
                                    3'd4: begin
                                        dec     = bcd_in(i_data & 8'h3f);
                                        n_day   = (dec > 8'd31) ? 5'd31 : dec[4:0];
                                        n_state = i2crtc_pkg::ST_CLAMP;
                                    end
                                    3'd5: begin
                                        dec     = bcd_in(i_data & 8'h1f);
                                        n_mon   = (dec < 8'd1) ? 4'd1 :
                                                  (dec > 8'd12) ? 4'd12 : dec[3:0];
                                        n_state = i2crtc_pkg::ST_CLAMP;
                                    end
                                    default: begin
                                        dec     = bcd_in(i_data);
                                        n_year  = (dec > 8'd99) ? 7'd99 : dec[6:0];
                                        n_state = i2crtc_pkg::ST_CLAMP;
                                    end
                                endcase
                            end else if (r_ptr == i2crtc_pkg::CTRL_REG) begin
                                // old control byte arrives next cycle for the osf merge
                                n_ptr   = r_ptr + PW'(1);
                                n_state = i2crtc_pkg::ST_CTRL;
                            end else begin
                                mem_we = 1'b1;
                                n_ptr  = r_ptr + PW'(1);
                                if (r_ptr == '1) do_snap = 1'b1;
                            end
                        end
                        i2crtc_pkg::KIND_READ: begin
                            n_rd_idx = r_ptr;
                            n_ptr    = r_ptr + PW'(1);
                            n_state  = i2crtc_pkg::ST_READ;
                            if (r_ptr == '1) do_snap = 1'b1;
                        end
                        i2crtc_pkg::KIND_TICK: begin
                            if (r_sec < 6'd59) begin
                                n_sec = r_sec + 6'd1;
                            end else begin
                                n_sec = 6'd0;
                                if (r_min < 6'd59) begin
                                    n_min = r_min + 6'd1;
                                end else begin
                                    n_min = 6'd0;
                                    if (r_hour < 5'd23) begin
                                        n_hour = r_hour + 5'd1;
                                    end else begin
                                        n_hour = 5'd0;
                                        n_wday = (r_wday >= 3'd6) ? 3'd0 : r_wday + 3'd1;
                                        if (r_day < dim) begin
                                            n_day = r_day + 5'd1;
                                        end else begin
                                            n_day = 5'd1;
                                            if (r_mon < 4'd12) begin
                                                n_mon = r_mon + 4'd1;
                                            end else begin
                                                n_mon  = 4'd1;
                                                n_year = (r_year >= 7'd99) ? 7'd0
                                                                           : r_year + 7'd1;
                                            end
                                        end
                                    end
                                end
                            end
                        end
                        default: ;
                    endcase
                end
            end
            i2crtc_pkg::ST_CLAMP: begin
                if (r_day == 5'd0) begin
                    n_day = 5'd1;
                end else if (r_day > dim) begin
                    n_day = dim;
                end
                n_state = i2crtc_pkg::ST_IDLE;
            end
            i2crtc_pkg::ST_CTRL: begin
                mem_we  = 1'b1;
                mem_wa  = i2crtc_pkg::CTRL_REG;
                mem_wd  = ((r_data & i2crtc_pkg::CTRL_MASK) & ~i2crtc_pkg::OSF_BIT)
                        | (r_data & old & i2crtc_pkg::OSF_BIT);
                n_state = i2crtc_pkg::ST_IDLE;
            end
            i2crtc_pkg::ST_READ: begin
                n_state = i2crtc_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= i2crtc_pkg::ST_IDLE;
            r_ptr    <= '0;
            r_aphase <= 1'b0;
            r_sec    <= 6'd0;
            r_min    <= 6'd0;
            r_hour   <= 5'd0;
            r_wday   <= 3'd6;
            r_day    <= 5'd1;
            r_mon    <= 4'd1;
            r_year   <= 7'd0;
            r_h12    <= 1'b0;
            r_vld    <= '0;
            for (int i = 0; i < i2crtc_pkg::TIME_REGS; i++) begin
                r_snap[i] <= 8'd0;
            end
        end else begin
            r_state  <= n_state;
            r_ptr    <= n_ptr;
            r_aphase <= n_aphase;
            r_sec    <= n_sec;
            r_min    <= n_min;
            r_hour   <= n_hour;
            r_wday   <= n_wday;
            r_day    <= n_day;
            r_mon    <= n_mon;
            r_year   <= n_year;
            r_h12    <= n_h12;
            if (mem_we) r_vld[mem_wa] <= 1'b1;
            if (do_snap) begin
                for (int i = 0; i < i2crtc_pkg::TIME_REGS; i++) begin
                    r_snap[i] <= n_snap[i];
                end
            end
        end
    end

    // payload and store ram, no reset
    always_ff @(posedge i_clk) begin
        r_rd_idx <= n_rd_idx;
        if (!busy) r_data <= i_data;
        if (mem_we) r_mem[mem_wa] <= mem_wd;
        r_rdata  <= r_mem[r_ptr];
        r_rd_vld <= r_vld[r_ptr];
    end

    assign o_valid      = (r_state == i2crtc_pkg::ST_READ);
    assign o_read_index = 6'(r_rd_idx);
    assign o_read_data  = (r_rd_idx < PW'(i2crtc_pkg::TIME_REGS)) ? r_snap[r_rd_idx[2:0]]
                        : (r_rd_vld ? r_rdata : 8'd0);

endmodule

@@ rtl/i2crtc_checker.sv @@
// port-level checks on command acceptance and read strobe timing
module i2crtc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic [2:0] i_kind,
    input logic       busy,
    input logic       o_valid,
    input logic [5:0] o_read_index
);

    logic rd_take;
    logic other_take;

    assign rd_take    = start && !busy && (i_kind == i2crtc_pkg::KIND_READ);
    assign other_take = start && !busy && (i_kind != i2crtc_pkg::KIND_READ);

    a_read_gives_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rd_take |=> o_valid)
        else $error("read transaction gave no result strobe");

    a_strobe_from_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(rd_take))
        else $error("result strobe without a read transaction");

    a_no_result_otherwise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        other_take |=> !o_valid)
        else $error("result strobe after a non-read transaction");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_index_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid ##2 (o_valid && $past(rd_take) && $past(o_valid, 2)
            && !$past(rd_take, 2) && !$past(other_take, 2))
        |-> o_read_index == $past(o_read_index, 2) + 6'd1)
        else $error("back-to-back reads did not advance the index");

endmodule

bind i2c_rtc_register_file_core i2crtc_checker u_i2crtc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .start        (start),
    .i_kind       (i_kind),
    .busy         (busy),
    .o_valid      (o_valid),
    .o_read_index (o_read_index)
);

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// testbench for the i2c rtc register file core with a calendar scoreboard and random bus traffic
module tb;

    typedef logic [i2crtc_pkg::PTR_W-1:0] t_ptr;

    typedef struct {
        logic [7:0] data;
        t_ptr       idx;
    } t_read_beat;

    class rtc_scoreboard;
        t_ptr             reg_ptr;
        bit               want_ptr;
        logic [7:0]       mem [i2crtc_pkg::STORE_DEPTH];
        logic [5:0]       sec;
        logic [5:0]       mins;
        logic [4:0]       hour;
        logic [2:0]       wday;
        logic [4:0]       mday;
        logic [3:0]       mon;
        logic [6:0]       yr;
        bit               mode12;
        t_read_beat       reads_due [$];
        int               errors;

        function new();
            reg_ptr  = '0;
            want_ptr = 1'b0;
            foreach (mem[i]) mem[i] = 8'h00;
            sec      = 0;
            mins     = 0;
            hour     = 0;
            wday     = 6;
            mday     = 1;
            mon      = 1;
            yr       = 0;
            mode12   = 1'b0;
            errors   = 0;
        endfunction

        static function logic [7:0] to_bcd(int v);
            return 8'(((v / 10) << 4) | (v % 10));
        endfunction

        static function int bcd_value(logic [7:0] b);
            return int'(b[7:4]) * 10 + int'(b[3:0]);
        endfunction

        function int pending();
            return reads_due.size();
        endfunction

        function int month_len();
            case (mon)
                4'd2:                    return (yr % 4 == 0) ? 29 : 28;
                4'd4, 4'd6, 4'd9, 4'd11: return 30;
                default:                 return 31;
            endcase
        endfunction

        function void clamp_day();
            if (mday < 1) mday = 1;
            if (mday > month_len()) mday = 5'(month_len());
        endfunction

        // bcd copy of the counters into store bytes 0 to 6
        function void snapshot();
            int h;
            mem[0] = to_bcd(sec);
            mem[1] = to_bcd(mins);
            if (mode12) begin
                h = hour;
                if (h % 12 == 0) h += 12;
                if (h <= 12) mem[2] = i2crtc_pkg::HOUR_12 | to_bcd(h);
                else mem[2] = i2crtc_pkg::HOUR_12 | i2crtc_pkg::HOUR_PM | to_bcd(h - 12);
            end else begin
                mem[2] = to_bcd(hour);
            end
            mem[3] = 8'(wday % 7 + 1);
            mem[4] = to_bcd(mday);
            mem[5] = to_bcd(mon);
            mem[6] = to_bcd(yr);
        endfunction

        function void step_ptr();
            reg_ptr = reg_ptr + 1'b1;
            if (reg_ptr == 0) snapshot();
        endfunction

        function void tick();
            if (sec < 59) begin
                sec++;
                return;
            end
            sec = 0;
            if (mins < 59) begin
                mins++;
                return;
            end
            mins = 0;
            if (hour < 23) begin
                hour++;
                return;
            end
            hour = 0;
            wday = 3'((wday + 1) % 7);
            if (mday < month_len()) begin
                mday++;
                return;
            end
            mday = 1;
            if (mon < 12) begin
                mon++;
                return;
            end
            mon = 1;
            yr  = 7'((yr + 1) % 100);
        endfunction

        function void write_time(int r, logic [7:0] d);
            int v;
            case (r)
                0: begin
                    v   = bcd_value(d & 8'h7f);
                    sec = 6'((v > 59) ? 59 : v);
                end
                1: begin
                    v    = bcd_value(d & 8'h7f);
                    mins = 6'((v > 59) ? 59 : v);
                end
                2: begin
                    mode12 = (d & i2crtc_pkg::HOUR_12) != 0;
                    if (mode12) begin
                        v = bcd_value(d & 8'h1f);
                        if (v > 12) v = 12;
                        if (v < 1) v = 1;
                        if ((d & i2crtc_pkg::HOUR_PM) != 0) v += 12;
                        // 12 am is midnight, 12 pm is noon
                        if (v % 12 == 0) v -= 12;
                    end else begin
                        v = bcd_value(d & 8'h3f);
                        if (v > 23) v = 23;
                    end
                    hour = 5'(v);
                end
                3: wday = 3'(((d & 8'h07) + 6) % 7);
                4: begin
                    v = bcd_value(d & 8'h3f);
                    if (v < 1) v = 1;
                    if (v > month_len()) v = month_len();
                    mday = 5'(v);
                end
                5: begin
                    v   = bcd_value(d & 8'h1f);
                    mon = 4'((v < 1) ? 1 : ((v > 12) ? 12 : v));
                    clamp_day();
                end
                default: begin
                    v  = bcd_value(d);
                    yr = 7'((v > 99) ? 99 : v);
                    clamp_day();
                end
            endcase
        endfunction

        function void note_command(logic [2:0] kind, logic [7:0] d);
            logic [7:0] v;
            t_read_beat beat;
            case (kind)
                i2crtc_pkg::KIND_START_READ:  snapshot();
                i2crtc_pkg::KIND_START_WRITE: want_ptr = 1'b1;
                i2crtc_pkg::KIND_WRITE: begin
                    if (want_ptr) begin
                        reg_ptr  = t_ptr'(d % i2crtc_pkg::STORE_DEPTH);
                        want_ptr = 1'b0;
                    end else begin
                        if (reg_ptr < i2crtc_pkg::TIME_REGS) begin
                            write_time(int'(reg_ptr), d);
                        end else if (reg_ptr == i2crtc_pkg::CTRL_REG) begin
                            // osf may be cleared or kept, never set
                            v            = d & i2crtc_pkg::CTRL_MASK;
                            mem[reg_ptr] = (v & ~i2crtc_pkg::OSF_BIT)
                                         | (v & mem[reg_ptr] & i2crtc_pkg::OSF_BIT);
                        end else begin
                            mem[reg_ptr] = d;
                        end
                        step_ptr();
                    end
                end
                i2crtc_pkg::KIND_READ: begin
                    beat.data = mem[reg_ptr];
                    beat.idx  = reg_ptr;
                    reads_due.push_back(beat);
                    step_ptr();
                end
                i2crtc_pkg::KIND_TICK: tick();
                default: ;
            endcase
        endfunction

        function void check_result(logic [7:0] d, t_ptr idx);
            t_read_beat want;
            if (reads_due.size() == 0) begin
                errors++;
                $display("%0t: read result with none expected, actual data %02h index %0d",
                         $time, d, idx);
                return;
            end
            want = reads_due.pop_front();
            if (d !== want.data) begin
                errors++;
                $display("%0t: read_data expected %02h actual %02h", $time, want.data, d);
            end
            if (idx !== want.idx) begin
                errors++;
                $display("%0t: read_index expected %0d actual %0d", $time, want.idx, idx);
            end
        endfunction
    endclass

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       start   = 1'b0;
    logic [2:0] i_kind  = i2crtc_pkg::KIND_START_READ;
    logic [7:0] i_data  = 8'h00;
    logic       busy;
    logic       o_valid;
    logic [7:0] o_read_data;
    logic [5:0] o_read_index;

    rtc_scoreboard board;
    int            sent    = 0;
    bit            no_gaps = 1'b0;

    i2c_rtc_register_file_core uut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .i_kind       (i_kind),
        .i_data       (i_data),
        .busy         (busy),
        .o_valid      (o_valid),
        .o_read_data  (o_read_data),
        .o_read_index (o_read_index)
    );

    always #5 i_clk = ~i_clk;

    // results first, then the transaction taken at this edge
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid) board.check_result(o_read_data, o_read_index);
            if (start && !busy) board.note_command(i_kind, i_data);
        end
    end

    task automatic send(input logic [2:0] kind, input logic [7:0] d);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 13);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_kind <= kind;
        i_data <= d;
        do @(posedge i_clk); while (busy);
        if (kind <= i2crtc_pkg::KIND_TICK) sent++;
    endtask

    task automatic wait_results();
        int n;
        start <= 1'b0;
        n = 0;
        do begin
            @(posedge i_clk);
            n++;
        end while (board.pending() > 0 && n < 200);
    endtask

    task automatic set_pointer(input logic [7:0] p);
        send(i2crtc_pkg::KIND_START_WRITE, 8'($urandom));
        send(i2crtc_pkg::KIND_WRITE, p);
    endtask

    function automatic logic [7:0] pick_pointer();
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: return 8'($urandom_range(0, 8));
            5, 6:          return 8'($urandom_range(i2crtc_pkg::STORE_DEPTH - 8,
                                                    i2crtc_pkg::STORE_DEPTH - 1));
            7:             return 8'($urandom);
            default:       return 8'($urandom_range(0, i2crtc_pkg::STORE_DEPTH - 1));
        endcase
    endfunction

    // mostly well-formed bcd for the time registers, random bytes from the control register up
    function automatic logic [7:0] calendar_byte(input int r);
        if ($urandom_range(0, 3) == 0) return 8'($urandom);
        case (r)
            0, 1: return rtc_scoreboard::to_bcd($urandom_range(0, 59))
                         | 8'($urandom_range(0, 1) << 7);
            2: begin
                if ($urandom_range(0, 1) == 1)
                    return i2crtc_pkg::HOUR_12
                           | ($urandom_range(0, 1) ? i2crtc_pkg::HOUR_PM : 8'h00)
                           | rtc_scoreboard::to_bcd($urandom_range(1, 12));
                return rtc_scoreboard::to_bcd($urandom_range(0, 23));
            end
            3:       return 8'($urandom_range(0, 7));
            4:       return rtc_scoreboard::to_bcd($urandom_range(1, 31));
            5:       return rtc_scoreboard::to_bcd($urandom_range(1, 12));
            6:       return rtc_scoreboard::to_bcd($urandom_range(0, 99));
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic write_burst();
        logic [7:0] p;
        int         n;
        int         cur;
        p   = pick_pointer();
        cur = p % i2crtc_pkg::STORE_DEPTH;
        set_pointer(p);
        n = $urandom_range(1, 8);
        repeat (n) begin
            send(i2crtc_pkg::KIND_WRITE, calendar_byte(cur));
            cur = (cur + 1) % i2crtc_pkg::STORE_DEPTH;
        end
    endtask

    task automatic read_burst();
        int n;
        if ($urandom_range(0, 2) != 0) set_pointer(pick_pointer());
        send(i2crtc_pkg::KIND_START_READ, 8'($urandom));
        n = $urandom_range(1, 10);
        repeat (n) send(i2crtc_pkg::KIND_READ, 8'($urandom));
    endtask

    // time set just short of a rollover, then ticks and a full read back
    task automatic rollover_run();
        int n;
        set_pointer(8'h00);
        send(i2crtc_pkg::KIND_WRITE, rtc_scoreboard::to_bcd($urandom_range(55, 59)));
        send(i2crtc_pkg::KIND_WRITE, 8'h59);
        case ($urandom_range(0, 2))
            0:       send(i2crtc_pkg::KIND_WRITE, 8'h23);
            1:       send(i2crtc_pkg::KIND_WRITE, 8'h71);
            default: send(i2crtc_pkg::KIND_WRITE, 8'h52);
        endcase
        send(i2crtc_pkg::KIND_WRITE, 8'($urandom_range(0, 7)));
        send(i2crtc_pkg::KIND_WRITE, rtc_scoreboard::to_bcd($urandom_range(28, 31)));
        send(i2crtc_pkg::KIND_WRITE, ($urandom_range(0, 2) == 0) ? 8'h12 :
                                     rtc_scoreboard::to_bcd($urandom_range(1, 12)));
        send(i2crtc_pkg::KIND_WRITE, ($urandom_range(0, 3) == 0) ? 8'h99 :
                                     rtc_scoreboard::to_bcd($urandom_range(0, 99)));
        n = $urandom_range(1, 8);
        repeat (n) send(i2crtc_pkg::KIND_TICK, 8'($urandom));
        set_pointer(8'h00);
        send(i2crtc_pkg::KIND_START_READ, 8'($urandom));
        repeat (8) send(i2crtc_pkg::KIND_READ, 8'($urandom));
    endtask

    initial begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    initial begin
        int n;
        board = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // saturating time writes, 12 pm hour, weekday code zero, control byte all ones
        set_pointer(8'h00);
        send(i2crtc_pkg::KIND_WRITE, 8'h99);
        send(i2crtc_pkg::KIND_WRITE, 8'hFF);
        send(i2crtc_pkg::KIND_WRITE, 8'h72);
        send(i2crtc_pkg::KIND_WRITE, 8'h00);
        send(i2crtc_pkg::KIND_WRITE, 8'h3F);
        send(i2crtc_pkg::KIND_WRITE, 8'h1F);
        send(i2crtc_pkg::KIND_WRITE, 8'hFF);
        send(i2crtc_pkg::KIND_WRITE, 8'hFF);
        send(i2crtc_pkg::KIND_TICK, 8'h00);
        send(3'd5, 8'hFF);
        send(3'd7, 8'h00);
        // pointer byte above the store depth, then a write that wraps to 0
        set_pointer(8'hFF);
        send(i2crtc_pkg::KIND_WRITE, 8'h5A);
        send(i2crtc_pkg::KIND_START_READ, 8'h00);
        repeat (8) send(i2crtc_pkg::KIND_READ, 8'hFF);
        wait_results();

        while (sent < 625) begin
            no_gaps = ($urandom_range(0, 3) == 0);
            case ($urandom_range(0, 9))
                0, 1, 2: write_burst();
                3, 4, 5: read_burst();
                6:       rollover_run();
                7: begin
                    n = $urandom_range(1, 6);
                    repeat (n) send(i2crtc_pkg::KIND_TICK, 8'($urandom));
                end
                8: begin
                    n = $urandom_range(1, 3);
                    repeat (n) send(3'($urandom_range(0, 7)), 8'($urandom));
                end
                default: begin
                    // start of write with another command between it and the pointer byte
                    send(i2crtc_pkg::KIND_START_WRITE, 8'($urandom));
                    case ($urandom_range(0, 2))
                        0:       send(i2crtc_pkg::KIND_START_READ, 8'($urandom));
                        1:       send(i2crtc_pkg::KIND_READ, 8'($urandom));
                        default: send(i2crtc_pkg::KIND_TICK, 8'($urandom));
                    endcase
                    send(i2crtc_pkg::KIND_WRITE, 8'($urandom));
                    send(i2crtc_pkg::KIND_WRITE, 8'($urandom));
                end
            endcase
            if ($urandom_range(0, 14) == 0) wait_results();
        end

        wait_results();
        repeat (10) @(posedge i_clk);
        if (board.pending() != 0) begin
            board.errors++;
            $display("%0t: %0d expected read results never arrived", $time, board.pending());
        end
        if (board.errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
